// ----- hdl/ccc_pkg.sv -----
// Shared constants and types for the cube coin change counter.
package ccc_pkg;

  localparam int AMOUNT_W      = 14;
  localparam int WAYS_W        = 64;
  localparam int KINDS_W       = 5;
  localparam int KINDS_RESET   = 21;
  localparam int AMOUNT_DEPTH  = 16384;
  localparam int MAX_COIN_KINDS = 21;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQUARE,
    ST_CUBE,
    ST_CHECK,
    ST_READ,
    ST_UPDATE,
    ST_QREAD,
    ST_QOUT
  } state_e;

endpackage

// ----- hdl/ccc_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module ccc_ram #(
  parameter int W     = 65,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [W-1:0]             rdata_a_o,
  output logic [W-1:0]             rdata_b_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_a_q;
  logic [W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- hdl/cube_coin_change_counter.sv -----
// Top level: table-based count of ways to pay an amount with cube coins.
//
//   channel  | signals                    | direction | handshake
//   query    | start, amount_i            | in        | start && !busy
//   result   | strobe_o, ways_o, saturated_o | out    | strobe_o, one cycle, no stall
//   config   | cfg_we_i, cfg_wdata_i      | in        | cfg_we_i
//
// A query with the table built reads the entry in ST_QREAD and raises the strobe in
// ST_QOUT; busy falls after ST_QOUT, so a new query is taken only once the last
// result has been given.
// The first query after reset or a coin_kinds write rebuilds the table first:
// a clearing pass over every entry, then per coin in use a square, cube and check
// step and a read and update of each entry from the coin value up, and a final
// step to close the sweep, paced by the read-modify-write of each entry through the
// registered-read table RAM and the one shared 64-bit adder.
// busy stays high from transfer to strobe; results cannot be held off.
module cube_coin_change_counter #(
  parameter int AMOUNT_DEPTH   = ccc_pkg::AMOUNT_DEPTH,
  parameter int MAX_COIN_KINDS = ccc_pkg::MAX_COIN_KINDS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ccc_pkg::AMOUNT_W-1:0] amount_i,
  output logic                         strobe_o,
  output logic [ccc_pkg::WAYS_W-1:0]   ways_o,
  output logic                         saturated_o,
  input  logic                         cfg_we_i,
  input  logic [ccc_pkg::KINDS_W-1:0]  cfg_wdata_i
);

  localparam int AW     = $clog2(AMOUNT_DEPTH);
  localparam int KW     = $clog2(MAX_COIN_KINDS + 2);
  localparam int CUBE_W = 3 * KW;
  localparam int CMP_W  = (CUBE_W > AW + 1) ? CUBE_W : AW + 1;
  localparam int KC_W   = (KW > ccc_pkg::KINDS_W) ? KW : ccc_pkg::KINDS_W;
  localparam int AMT_CW = (AW + 1 > ccc_pkg::AMOUNT_W) ? AW + 1 : ccc_pkg::AMOUNT_W;
  localparam int WW     = ccc_pkg::WAYS_W;
  localparam int MEM_W  = WW + 1;

  ccc_pkg::state_e state_q, state_d;

  logic [ccc_pkg::KINDS_W-1:0]  kinds_q;
  logic                         ready_q, ready_d;
  logic [ccc_pkg::AMOUNT_W-1:0] amount_q, amount_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic [KW-1:0]                k_q, k_d;
  logic [2*KW-1:0]              prod_q, prod_d;
  logic [CUBE_W-1:0]            coin_q, coin_d;

  logic [KC_W-1:0]   kinds_eff;
  logic              k_done;
  logic              coin_big;
  logic [AW-1:0]     coin_a;
  logic              last_addr;
  logic              in_range;
  logic [2*KW-1:0]   k_sq_ext;
  logic [CUBE_W-1:0] prod_ext;
  logic [CUBE_W-1:0] k_cu_ext;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MEM_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr_a;
  logic [AW-1:0]    ram_raddr_b;
  logic [MEM_W-1:0] ram_rdata_a;
  logic [MEM_W-1:0] ram_rdata_b;

  logic [WW:0] sum;
  logic        over;

  ccc_ram #(
    .W     (MEM_W),
    .DEPTH (AMOUNT_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign kinds_eff = (KC_W'(kinds_q) > KC_W'(MAX_COIN_KINDS)) ?
                     KC_W'(MAX_COIN_KINDS) : KC_W'(kinds_q);
  assign k_done    = KC_W'(k_q) > kinds_eff;
  assign coin_big  = CMP_W'(coin_q) >= CMP_W'(AMOUNT_DEPTH);
  assign coin_a    = AW'(coin_q);
  assign last_addr = addr_q == AW'(AMOUNT_DEPTH - 1);
  assign in_range  = AMT_CW'(amount_q) < AMT_CW'(AMOUNT_DEPTH);
  assign k_sq_ext  = (2*KW)'(k_q);
  assign prod_ext  = CUBE_W'(prod_q);
  assign k_cu_ext  = CUBE_W'(k_q);

  // Shared adder: entry plus entry one coin back, saturating
  assign sum  = {1'b0, ram_rdata_a[WW-1:0]} + {1'b0, ram_rdata_b[WW-1:0]};
  assign over = ram_rdata_a[WW] | ram_rdata_b[WW] | sum[WW];

  // Next state and sequencer counters
  always_comb begin
    state_d  = state_q;
    ready_d  = ready_q;
    amount_d = amount_q;
    addr_d   = addr_q;
    k_d      = k_q;
    prod_d   = prod_q;
    coin_d   = coin_q;
    case (state_q)
      ccc_pkg::ST_IDLE: begin
        if (start) begin
          amount_d = amount_i;
          if (ready_q) begin
            state_d = ccc_pkg::ST_QREAD;
          end else begin
            addr_d  = '0;
            state_d = ccc_pkg::ST_CLEAR;
          end
        end
      end
      ccc_pkg::ST_CLEAR: begin
        if (last_addr) begin
          k_d     = KW'(1);
          state_d = ccc_pkg::ST_SQUARE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ccc_pkg::ST_SQUARE: begin
        if (k_done) begin
          ready_d = 1'b1;
          state_d = ccc_pkg::ST_QREAD;
        end else begin
          prod_d  = k_sq_ext * k_sq_ext;
          state_d = ccc_pkg::ST_CUBE;
        end
      end
      ccc_pkg::ST_CUBE: begin
        coin_d  = prod_ext * k_cu_ext;
        state_d = ccc_pkg::ST_CHECK;
      end
      ccc_pkg::ST_CHECK: begin
        // Cubes only grow: once one is out of the table, so are the rest
        if (coin_big) begin
          ready_d = 1'b1;
          state_d = ccc_pkg::ST_QREAD;
        end else begin
          addr_d  = coin_a;
          state_d = ccc_pkg::ST_READ;
        end
      end
      ccc_pkg::ST_READ: begin
        state_d = ccc_pkg::ST_UPDATE;
      end
      ccc_pkg::ST_UPDATE: begin
        if (last_addr) begin
          k_d     = k_q + KW'(1);
          state_d = ccc_pkg::ST_SQUARE;
        end else begin
          addr_d  = addr_q + AW'(1);
          state_d = ccc_pkg::ST_READ;
        end
      end
      ccc_pkg::ST_QREAD: begin
        state_d = ccc_pkg::ST_QOUT;
      end
      ccc_pkg::ST_QOUT: begin
        state_d = ccc_pkg::ST_IDLE;
      end
      default: begin
        state_d = ccc_pkg::ST_IDLE;
      end
    endcase
  end

  // Table port control and result strobe
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    ram_raddr_a = addr_q;
    ram_raddr_b = addr_q;
    strobe_o    = 1'b0;
    case (state_q)
      ccc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (addr_q == '0) ? MEM_W'(1) : '0;
      end
      ccc_pkg::ST_READ: begin
        ram_raddr_b = addr_q - coin_a;
      end
      ccc_pkg::ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_wdata = over ? {1'b1, {WW{1'b1}}} : {1'b0, sum[WW-1:0]};
      end
      ccc_pkg::ST_QREAD: begin
        ram_raddr_a = AW'(amount_q);
      end
      ccc_pkg::ST_QOUT: begin
        strobe_o = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign busy        = state_q != ccc_pkg::ST_IDLE;
  assign ways_o      = (strobe_o && in_range) ? ram_rdata_a[WW-1:0] : '0;
  assign saturated_o = strobe_o && in_range && ram_rdata_a[WW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccc_pkg::ST_IDLE;
      kinds_q <= ccc_pkg::KINDS_W'(ccc_pkg::KINDS_RESET);
      ready_q <= 1'b0;
      addr_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      k_q     <= k_d;
      if (cfg_we_i) begin
        kinds_q <= cfg_wdata_i;
        ready_q <= 1'b0;
      end else begin
        ready_q <= ready_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    amount_q <= amount_d;
    prod_q   <= prod_d;
    coin_q   <= coin_d;
  end

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held longer than one cycle");

  a_strobe_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ready_q)
    else $error("result given before the table was built");

  a_write_build : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ccc_pkg::ST_CLEAR || state_q == ccc_pkg::ST_UPDATE))
    else $error("table written outside a build");

  a_sat_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> (ways_o == {WW{1'b1}}))
    else $error("saturated count not all ones");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transfer taken without going busy");

endmodule
